// File: rtl/gbn_win_pkg.sv
// Shared types and constants for the Go-Back-N sender window unit.
// No dependencies; imported by go_back_n_sender_window_unit.
package gbn_win_pkg;

   // Event codes carried by the kind field of an input transaction.
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   // Configuration register indexes.
   localparam int          CSR_INDEX_W           = 3;
   localparam logic [2:0]  CSR_PACKET_TOTAL      = 3'd0;
   localparam logic [2:0]  CSR_INITIAL_THRESHOLD = 3'd1;
   localparam logic [2:0]  CSR_WINDOW_LIMIT      = 3'd2;
   localparam logic [2:0]  CSR_RETRY_LIMIT       = 3'd3;

   // Most result transactions released by one event.
   localparam int          MAX_RESULTS = 32;
   localparam int          COUNT_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SENDING = 2'd1,
      PH_DONE    = 2'd2,
      PH_FAILED  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ACK_LO,
      S_ACK_HI,
      S_ACK_NTS,
      S_CNT_WIN,
      S_CNT_TOT,
      S_EMIT
   } state_type;

   // Operand pairs for the shared 33-bit subtractor.
   typedef enum logic [2:0] {
      ALU_ACK_BASE,
      ALU_ACK_TOTAL,
      ALU_ACK_NTS,
      ALU_NTS_BASE,
      ALU_TOTAL_NTS
   } alu_sel_type;

endpackage

// File: rtl/go_back_n_sender_window_unit.sv
// Go-Back-N sender window with slow start congestion control.
// Depends on gbn_win_pkg (state, phase and operand-select types, codes).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_stall  | req_kind, req_ack_seq
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_send_valid .. rsp_threshold_now
//   csr     | in        | csr_write            | csr_index, csr_wdata
//
// After the accepting edge an event passes through S_DECODE, then, for an ACK while
// sending, the ACK checks S_ACK_LO, S_ACK_HI and S_ACK_NTS (stopping after S_ACK_LO
// for an ACK below the base and after S_ACK_HI for one past the end; all three for
// one inside the window), then S_CNT_WIN and, while sending, S_CNT_TOT. In S_EMIT
// it emits one transaction per released sequence number, up to 32, or the single
// status transaction, and then returns to S_IDLE, where the next event is accepted.
// The sequencer runs every wide compare through one shared 33-bit subtractor.
// Reset is synchronous and active high; it loads the register defaults and idles.
// A stall on rsp holds the emitting sequencer; req is stalled while an event runs.

module go_back_n_sender_window_unit #(
   parameter int MAX_WINDOW = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // Event input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [31:0]                         req_ack_seq,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_send_valid,
   output logic [31:0]                         rsp_send_seq,
   output logic                                rsp_last,
   output logic                                rsp_done_res,
   output logic                                rsp_failed,
   output logic [5:0]                          rsp_window_now,
   output logic [5:0]                          rsp_threshold_now,
   // Configuration write port.
   input  logic                                csr_write,
   input  logic [gbn_win_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                         csr_wdata
);
   import gbn_win_pkg::*;

   // Hardware ceiling on the window: the parameter, but never more than a
   // 6-bit window can hold.
   localparam int         CAP_HW     = (MAX_WINDOW > 63) ? 63 : MAX_WINDOW;
   localparam logic [5:0] CAP_HW_VAL = CAP_HW[5:0];

   // Configuration registers.
   logic [31:0] total_ff, total_in;
   logic [5:0]  init_thr_ff, init_thr_in;
   logic [5:0]  win_lim_ff, win_lim_in;
   logic [7:0]  retry_lim_ff, retry_lim_in;

   // Sequencer and event latch.
   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] ack_ff, ack_in;

   // Window state.
   logic [31:0] base_ff, base_in;
   logic [31:0] nts_ff, nts_in;
   logic [5:0]  cwnd_ff, cwnd_in;
   logic [5:0]  ssth_ff, ssth_in;
   logic [8:0]  streak_ff, streak_in;
   phase_type   phase_ff, phase_in;

   // Scratch values carried between sequencer steps.
   logic [6:0]         acked_ff, acked_in;
   logic               done_hit_ff, done_hit_in;
   logic [6:0]         rem_win_ff, rem_win_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_send_valid_ff, rsp_send_valid_in;
   logic [31:0] rsp_send_seq_ff, rsp_send_seq_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;
   logic        rsp_failed_ff, rsp_failed_in;
   logic [5:0]  rsp_win_ff, rsp_win_in;
   logic [5:0]  rsp_thr_ff, rsp_thr_in;

   // Shared arithmetic.
   alu_sel_type alu_sel;
   logic [31:0] alu_a, alu_b;
   logic [32:0] alu_diff;
   logic        alu_borrow;
   logic [31:0] inc_src, inc_out;

   logic        req_fire;
   logic        slot_free;
   logic        emit_fire;
   logic [5:0]  win_cap;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Effective window cap: min(window_limit, hardware ceiling), at least one.
   always_comb begin
      win_cap = (win_lim_ff > CAP_HW_VAL) ? CAP_HW_VAL : win_lim_ff;
      if (win_cap == 6'd0) begin
         win_cap = 6'd1;
      end
   end

   // The one wide subtractor that the sequencer's compare steps share.
   always_comb begin
      unique case (alu_sel)
         ALU_ACK_BASE: begin
            alu_a = ack_ff;
            alu_b = base_ff;
         end
         ALU_ACK_TOTAL: begin
            alu_a = ack_ff;
            alu_b = total_ff;
         end
         ALU_ACK_NTS: begin
            alu_a = ack_ff;
            alu_b = nts_ff;
         end
         ALU_NTS_BASE: begin
            alu_a = nts_ff;
            alu_b = base_ff;
         end
         ALU_TOTAL_NTS: begin
            alu_a = total_ff;
            alu_b = nts_ff;
         end
         default: begin
            alu_a = ack_ff;
            alu_b = base_ff;
         end
      endcase
   end

   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_diff[32];

   // One incrementer serves both the new base after an ACK and the send pointer.
   assign inc_src = (state_ff == S_EMIT) ? nts_ff : ack_ff;
   assign inc_out = inc_src + 32'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (kind_ff == KIND_ACK && phase_ff == PH_SENDING) begin
               state_in = S_ACK_LO;
            end else begin
               state_in = S_CNT_WIN;
            end
         end
         S_ACK_LO: begin
            state_in = alu_borrow ? S_CNT_WIN : S_ACK_HI;
         end
         S_ACK_HI: begin
            state_in = alu_borrow ? S_ACK_NTS : S_CNT_WIN;
         end
         S_ACK_NTS: begin
            state_in = S_CNT_WIN;
         end
         S_CNT_WIN: begin
            state_in = (phase_ff == PH_SENDING) ? S_CNT_TOT : S_EMIT;
         end
         S_CNT_TOT: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free && count_ff <= COUNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs: subtractor operands and the result load strobe.
   always_comb begin
      alu_sel   = ALU_ACK_BASE;
      emit_fire = 1'b0;
      unique case (state_ff)
         S_ACK_LO:  alu_sel = ALU_ACK_BASE;
         S_ACK_HI:  alu_sel = ALU_ACK_TOTAL;
         S_ACK_NTS: alu_sel = ALU_ACK_NTS;
         S_CNT_WIN: alu_sel = ALU_NTS_BASE;
         S_CNT_TOT: alu_sel = ALU_TOTAL_NTS;
         S_EMIT:    emit_fire = slot_free;
         default:   alu_sel = ALU_ACK_BASE;
      endcase
   end

   // Datapath.
   always_comb begin
      logic [7:0] grown;
      logic [5:0] half;
      logic [8:0] streak_inc;
      logic [6:0] rem_tot;
      logic [6:0] cnt;

      total_in     = total_ff;
      init_thr_in  = init_thr_ff;
      win_lim_in   = win_lim_ff;
      retry_lim_in = retry_lim_ff;
      kind_in      = kind_ff;
      ack_in       = ack_ff;
      base_in      = base_ff;
      nts_in       = nts_ff;
      cwnd_in      = cwnd_ff;
      ssth_in      = ssth_ff;
      streak_in    = streak_ff;
      phase_in     = phase_ff;
      acked_in     = acked_ff;
      done_hit_in  = done_hit_ff;
      rem_win_in   = rem_win_ff;
      count_in     = count_ff;

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_send_valid_in = rsp_send_valid_ff;
      rsp_send_seq_in   = rsp_send_seq_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_done_in       = rsp_done_ff;
      rsp_failed_in     = rsp_failed_ff;
      rsp_win_in        = rsp_win_ff;
      rsp_thr_in        = rsp_thr_ff;

      grown      = 8'd0;
      half       = cwnd_ff >> 1;
      streak_inc = streak_ff + 9'd1;
      rem_tot    = 7'd0;
      cnt        = 7'd0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_PACKET_TOTAL:      total_in     = csr_wdata;
            CSR_INITIAL_THRESHOLD: init_thr_in  = csr_wdata[5:0];
            CSR_WINDOW_LIMIT:      win_lim_in   = csr_wdata[5:0];
            CSR_RETRY_LIMIT:       retry_lim_in = csr_wdata[7:0];
            default:               total_in     = total_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in = req_kind;
               ack_in  = req_ack_seq;
            end
         end
         S_DECODE: begin
            if (kind_ff == KIND_START) begin
               base_in   = 32'd0;
               nts_in    = 32'd0;
               cwnd_in   = 6'd1;
               ssth_in   = (init_thr_ff != 6'd0) ? init_thr_ff : 6'd1;
               streak_in = 9'd0;
               phase_in  = (total_ff == 32'd0) ? PH_DONE : PH_SENDING;
            end else if (kind_ff == KIND_TIMEOUT && phase_ff == PH_SENDING) begin
               ssth_in   = (half != 6'd0) ? half : 6'd1;
               cwnd_in   = 6'd1;
               streak_in = streak_inc;
               if (streak_inc > {1'b0, retry_lim_ff}) begin
                  phase_in = PH_FAILED;
               end else begin
                  nts_in = base_ff;
               end
            end
         end
         S_ACK_LO: begin
            // Packets covered by this ACK, saturated at 64, above any window.
            acked_in = (alu_diff[31:6] != 26'd0) ? 7'd64 : ({1'b0, alu_diff[5:0]} + 7'd1);
         end
         S_ACK_HI: begin
            // ack + 1 == total: the last packet is now acknowledged.
            done_hit_in = (alu_diff == {33{1'b1}});
         end
         S_ACK_NTS: begin
            base_in   = inc_out;
            streak_in = 9'd0;
            // Send pointer at or below the ACK jumps past it.
            if (!alu_borrow) begin
               nts_in = inc_out;
            end
            if (cwnd_ff < ssth_ff) begin
               grown = {2'b00, cwnd_ff} + {1'b0, acked_ff};
            end else begin
               grown = {2'b00, cwnd_ff} + 8'd1;
            end
            cwnd_in = (grown > {2'b00, win_cap}) ? win_cap : grown[5:0];
            if (done_hit_ff) begin
               phase_in = PH_DONE;
            end
         end
         S_CNT_WIN: begin
            // Room left in the window: cwnd minus packets already in flight.
            if (alu_diff[32:6] != 27'd0 || alu_diff[5:0] >= cwnd_ff) begin
               rem_win_in = 7'd0;
            end else begin
               rem_win_in = {1'b0, cwnd_ff - alu_diff[5:0]};
            end
            if (phase_ff != PH_SENDING) begin
               count_in = '0;
            end
         end
         S_CNT_TOT: begin
            if (alu_borrow) begin
               rem_tot = 7'd0;
            end else if (alu_diff[31:6] != 26'd0) begin
               rem_tot = 7'd64;
            end else begin
               rem_tot = {1'b0, alu_diff[5:0]};
            end
            cnt = (rem_win_ff < rem_tot) ? rem_win_ff : rem_tot;
            if (cnt > 7'(MAX_RESULTS)) begin
               cnt = 7'(MAX_RESULTS);
            end
            count_in = cnt[COUNT_W-1:0];
         end
         S_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_done_in   = (phase_ff == PH_DONE);
               rsp_failed_in = (phase_ff == PH_FAILED);
               rsp_win_in    = cwnd_ff;
               rsp_thr_in    = ssth_ff;
               if (count_ff == '0) begin
                  rsp_send_valid_in = 1'b0;
                  rsp_send_seq_in   = 32'd0;
                  rsp_last_in       = 1'b1;
               end else begin
                  rsp_send_valid_in = 1'b1;
                  rsp_send_seq_in   = nts_ff;
                  rsp_last_in       = (count_ff == COUNT_W'(1));
                  nts_in            = inc_out;
                  count_in          = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= 32'd1;
         init_thr_ff  <= 6'd16;
         win_lim_ff   <= 6'd32;
         retry_lim_ff <= 8'd10;
         base_ff      <= 32'd0;
         nts_ff       <= 32'd0;
         cwnd_ff      <= 6'd1;
         ssth_ff      <= 6'd16;
         streak_ff    <= 9'd0;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         init_thr_ff  <= init_thr_in;
         win_lim_ff   <= win_lim_in;
         retry_lim_ff <= retry_lim_in;
         base_ff      <= base_in;
         nts_ff       <= nts_in;
         cwnd_ff      <= cwnd_in;
         ssth_ff      <= ssth_in;
         streak_ff    <= streak_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scratch registers.
   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      ack_ff            <= ack_in;
      acked_ff          <= acked_in;
      done_hit_ff       <= done_hit_in;
      rem_win_ff        <= rem_win_in;
      rsp_send_valid_ff <= rsp_send_valid_in;
      rsp_send_seq_ff   <= rsp_send_seq_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_done_ff       <= rsp_done_in;
      rsp_failed_ff     <= rsp_failed_in;
      rsp_win_ff        <= rsp_win_in;
      rsp_thr_ff        <= rsp_thr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = rsp_send_valid_ff;
   assign rsp_send_seq      = rsp_send_seq_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_failed        = rsp_failed_ff;
   assign rsp_window_now    = rsp_win_ff;
   assign rsp_threshold_now = rsp_thr_ff;

   // The send pointer never falls behind the window base.
   a_nts_ahead: assert property (@(posedge clock) disable iff (reset)
      nts_ff >= base_ff)
      else $error("send pointer behind window base");

   // The congestion window is never empty.
   a_cwnd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cwnd_ff != 6'd0)
      else $error("congestion window is zero");

   // A status transaction always closes its event.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_send_valid_ff |-> rsp_last_ff)
      else $error("status transaction without last");

   // The burst count never exceeds one event's limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_RESULTS))
      else $error("burst count out of range");

   // Leaving the emit step happens only on the transaction flagged last.
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && state_in == S_IDLE |=> rsp_valid_ff && rsp_last_ff)
      else $error("event ended without a last transaction");

endmodule
